// ===== rtl/core/wfba_pkg.sv =====
`default_nettype none
package wfba_pkg;

   // Default number of words in the managed store.
   localparam int STORE_WORDS_DEF = 32768;
   // Positions run from 0 to the store size itself, so they need one bit
   // beyond a 16-bit header link.
   localparam int POS_W = 17;
   localparam int LAST_W = 16;
   localparam int HDR_W = 17;
   localparam int FIELD_W = 15;
   localparam int HDR_FREE_BIT = 16;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_A_EV,
      ST_SPLIT_HI,
      ST_SPLIT_LO,
      ST_F_CHK,
      ST_F_EV,
      ST_F_HEV,
      ST_F_EEV,
      ST_F_WR,
      ST_G_START,
      ST_G_EV,
      ST_DONE
   } state_type;

   typedef enum logic {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   typedef struct packed {
      logic               rd_en;
      logic               wr_en;
      logic [POS_W-1:0]   rd_addr;
      logic [POS_W-1:0]   wr_addr;
      logic [HDR_W-1:0]   wdata;
   } mem_req_type;

   typedef struct packed {
      logic               ok;
      logic [FIELD_W-1:0] block_index;
      logic [FIELD_W-1:0] free_words;
      logic [FIELD_W-1:0] largest_hole;
      logic [FIELD_W-1:0] hole_count;
   } result_type;

endpackage
`default_nettype wire

// ===== rtl/core/wfba_intf.sv =====
`default_nettype none
interface wfba_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [wfba_pkg::FIELD_W-1:0]  amount_or_index;

   modport source (output valid, output kind, output amount_or_index, input ready);
   modport sink (input valid, input kind, input amount_or_index, output ready);
endinterface

interface wfba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          ok;
   logic [wfba_pkg::FIELD_W-1:0]  block_index;
   logic [wfba_pkg::FIELD_W-1:0]  free_words;
   logic [wfba_pkg::FIELD_W-1:0]  largest_hole;
   logic [wfba_pkg::FIELD_W-1:0]  hole_count;

   modport source (output valid, output ok, output block_index, output free_words,
                   output largest_hole, output hole_count, input ready);
   modport sink (input valid, input ok, input block_index, input free_words,
                 input largest_hole, input hole_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/wfba_hdr_mem.sv =====
`default_nettype none
module wfba_hdr_mem #(
   parameter int STORE_WORDS = wfba_pkg::STORE_WORDS_DEF
) (
   input  wire                         clock,
   input  wire wfba_pkg::mem_req_type  mem_req,
   output logic [wfba_pkg::HDR_W-1:0]  rdata
);
   localparam int AW = $clog2(STORE_WORDS);

   logic [wfba_pkg::HDR_W-1:0] mem [STORE_WORDS];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rdata <= mem[mem_req.rd_addr[AW-1:0]];
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/wfba_ctrl.sv =====
`default_nettype none
module wfba_ctrl #(
   parameter int STORE_WORDS = wfba_pkg::STORE_WORDS_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                in_valid,
   output logic                               in_ready,
   input  wire                                in_kind,
   input  wire [wfba_pkg::FIELD_W-1:0]        in_arg,
   output logic                               res_valid,
   input  wire                                res_take,
   output wfba_pkg::result_type               res,
   output wfba_pkg::mem_req_type              mem_req,
   input  wire [wfba_pkg::HDR_W-1:0]          rdata
);
   localparam int PW = wfba_pkg::POS_W;
   localparam int LW = wfba_pkg::LAST_W;
   localparam int FW = wfba_pkg::FIELD_W;
   localparam logic [PW-1:0] STORE_POS = PW'(STORE_WORDS);
   localparam logic [PW-1:0] ONE = PW'(1);

   wfba_pkg::state_type state_ff, state_in;
   logic           kind_ff, kind_in;
   logic [FW-1:0]  arg_ff, arg_in;
   logic [PW-1:0]  h_ff, h_in;
   logic [PW-1:0]  best_ff, best_in;
   logic [PW-1:0]  best_h_ff, best_h_in;
   logic [LW-1:0]  best_last_ff, best_last_in;
   logic [PW-1:0]  prev_h_ff, prev_h_in;
   logic           prev_free_ff, prev_free_in;
   logic           has_prev_ff, has_prev_in;
   logic [PW-1:0]  end_ff, end_in;
   logic           ok_ff, ok_in;
   logic [FW-1:0]  idx_ff, idx_in;
   logic [PW-1:0]  total_ff, total_in;
   logic [PW-1:0]  largest_ff, largest_in;
   logic [PW-1:0]  count_ff, count_in;

   logic [LW-1:0]  last;
   logic           hdr_free;
   logic [PW-1:0]  nxt, size, arg_ext, target, split;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wfba_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      arg_ff       <= arg_in;
      h_ff         <= h_in;
      best_ff      <= best_in;
      best_h_ff    <= best_h_in;
      best_last_ff <= best_last_in;
      prev_h_ff    <= prev_h_in;
      prev_free_ff <= prev_free_in;
      has_prev_ff  <= has_prev_in;
      end_ff       <= end_in;
      ok_ff        <= ok_in;
      idx_ff       <= idx_in;
      total_ff     <= total_in;
      largest_ff   <= largest_in;
      count_ff     <= count_in;
   end

   always_comb begin
      last     = rdata[LW-1:0];
      hdr_free = rdata[wfba_pkg::HDR_FREE_BIT];
      nxt      = {1'b0, last} + ONE;
      size     = {1'b0, last} - h_ff;
      arg_ext  = PW'(arg_ff);
      target   = arg_ext - ONE;
      split    = best_h_ff + arg_ext + ONE;

      state_in     = state_ff;
      kind_in      = kind_ff;
      arg_in       = arg_ff;
      h_in         = h_ff;
      best_in      = best_ff;
      best_h_in    = best_h_ff;
      best_last_in = best_last_ff;
      prev_h_in    = prev_h_ff;
      prev_free_in = prev_free_ff;
      has_prev_in  = has_prev_ff;
      end_in       = end_ff;
      ok_in        = ok_ff;
      idx_in       = idx_ff;
      total_in     = total_ff;
      largest_in   = largest_ff;
      count_in     = count_ff;

      in_ready  = 1'b0;
      res_valid = 1'b0;
      mem_req   = '0;

      unique case (state_ff)
         wfba_pkg::ST_INIT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = '0;
            mem_req.wdata   = {1'b1, LW'(STORE_WORDS - 1)};
            state_in        = wfba_pkg::ST_IDLE;
         end
         wfba_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               kind_in     = in_kind;
               arg_in      = in_arg;
               ok_in       = 1'b0;
               idx_in      = '0;
               h_in        = '0;
               best_in     = '0;
               has_prev_in = 1'b0;
               if (in_arg == '0) begin
                  state_in = wfba_pkg::ST_G_START;
               end else if (in_kind == wfba_pkg::KIND_ALLOC) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = '0;
                  state_in        = wfba_pkg::ST_A_EV;
               end else begin
                  state_in = wfba_pkg::ST_F_CHK;
               end
            end
         end
         wfba_pkg::ST_A_EV: begin
            if (hdr_free && size == arg_ext) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = h_ff;
               mem_req.wdata   = {1'b0, last};
               ok_in           = 1'b1;
               idx_in          = FW'(h_ff + ONE);
               state_in        = wfba_pkg::ST_G_START;
            end else begin
               if (hdr_free && size > best_ff) begin
                  best_in      = size;
                  best_h_in    = h_ff;
                  best_last_in = last;
               end
               if (nxt >= STORE_POS) begin
                  if (best_in > arg_ext) begin
                     state_in = wfba_pkg::ST_SPLIT_HI;
                  end else begin
                     state_in = wfba_pkg::ST_G_START;
                  end
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = nxt;
                  h_in            = nxt;
               end
            end
         end
         wfba_pkg::ST_SPLIT_HI: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = split;
            mem_req.wdata   = {1'b1, best_last_ff};
            state_in        = wfba_pkg::ST_SPLIT_LO;
         end
         wfba_pkg::ST_SPLIT_LO: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = best_h_ff;
            mem_req.wdata   = {1'b0, LW'(best_h_ff + arg_ext)};
            ok_in           = 1'b1;
            idx_in          = FW'(best_h_ff + ONE);
            state_in        = wfba_pkg::ST_G_START;
         end
         wfba_pkg::ST_F_CHK: begin
            mem_req.rd_addr = h_ff;
            if (h_ff < STORE_POS && h_ff < target) begin
               mem_req.rd_en = 1'b1;
               state_in      = wfba_pkg::ST_F_EV;
            end else if (h_ff >= STORE_POS || h_ff != target) begin
               state_in = wfba_pkg::ST_G_START;
            end else begin
               mem_req.rd_en = 1'b1;
               state_in      = wfba_pkg::ST_F_HEV;
            end
         end
         wfba_pkg::ST_F_EV: begin
            prev_h_in    = h_ff;
            prev_free_in = hdr_free;
            has_prev_in  = 1'b1;
            h_in         = nxt;
            state_in     = wfba_pkg::ST_F_CHK;
         end
         wfba_pkg::ST_F_HEV: begin
            if (hdr_free) begin
               state_in = wfba_pkg::ST_G_START;
            end else begin
               end_in = nxt;
               if (nxt < STORE_POS) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = nxt;
                  state_in        = wfba_pkg::ST_F_EEV;
               end else begin
                  state_in = wfba_pkg::ST_F_WR;
               end
            end
         end
         wfba_pkg::ST_F_EEV: begin
            if (hdr_free) begin
               end_in = nxt;
            end
            state_in = wfba_pkg::ST_F_WR;
         end
         wfba_pkg::ST_F_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = (has_prev_ff && prev_free_ff) ? prev_h_ff : h_ff;
            mem_req.wdata   = {1'b1, LW'(end_ff - ONE)};
            ok_in           = 1'b1;
            state_in        = wfba_pkg::ST_G_START;
         end
         wfba_pkg::ST_G_START: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = '0;
            h_in            = '0;
            total_in        = '0;
            largest_in      = '0;
            count_in        = '0;
            state_in        = wfba_pkg::ST_G_EV;
         end
         wfba_pkg::ST_G_EV: begin
            if (hdr_free && size != '0) begin
               total_in = total_ff + size;
               count_in = count_ff + ONE;
               if (size > largest_ff) begin
                  largest_in = size;
               end
            end
            if (nxt >= STORE_POS) begin
               state_in = wfba_pkg::ST_DONE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = nxt;
               h_in            = nxt;
            end
         end
         wfba_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = wfba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wfba_pkg::ST_IDLE;
         end
      endcase

      res.ok           = ok_ff;
      res.block_index  = (kind_ff == wfba_pkg::KIND_ALLOC) ? idx_ff : '0;
      res.free_words   = FW'(total_ff);
      res.largest_hole = FW'(largest_ff);
      res.hole_count   = FW'(count_ff);
   end
endmodule
`default_nettype wire

// ===== rtl/core/worst_fit_block_allocator_top.sv =====
`default_nettype none
// An allocate walks the block chain, splits the chosen hole if needed and walks the chain
// again for hole statistics; a free walks to the block, merges it, then takes the same walk.
// No new item is taken until the block is back in idle; the walks over the header memory,
// one block at a time through its single read port, set the pace.
// Reset is synchronous and active high; the cycle after reset writes the first header,
// then the block accepts items. The other headers are undefined until written.
module worst_fit_block_allocator_top #(
   parameter int STORE_WORDS = wfba_pkg::STORE_WORDS_DEF
) (
   input  wire  clock,
   input  wire  reset,
   wfba_req_if.sink   req_if,
   wfba_rsp_if.source rsp_if
);
   // Header memory requests and read data between the sequencer and the store.
   wfba_pkg::mem_req_type        mem_req;
   logic [wfba_pkg::HDR_W-1:0]   mem_rdata;

   // Finished result handed from the sequencer to the output register.
   wfba_pkg::result_type         res;
   logic                         res_valid;
   logic                         res_take;

   logic                         rsp_valid_ff, rsp_valid_in;
   wfba_pkg::result_type         rsp_data_ff, rsp_data_in;

   wfba_hdr_mem #(.STORE_WORDS(STORE_WORDS)) u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   wfba_ctrl #(.STORE_WORDS(STORE_WORDS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_kind   (req_if.kind),
      .in_arg    (req_if.amount_or_index),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res),
      .mem_req   (mem_req),
      .rdata     (mem_rdata)
   );

   // The output register takes a new result when it is empty or its transfer
   // completes in this cycle, so the sequencer never waits on an idle consumer.
   always_comb begin
      res_take     = res_valid && (!rsp_valid_ff || rsp_if.ready);
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.ok           = rsp_data_ff.ok;
   assign rsp_if.block_index  = rsp_data_ff.block_index;
   assign rsp_if.free_words   = rsp_data_ff.free_words;
   assign rsp_if.largest_hole = rsp_data_ff.largest_hole;
   assign rsp_if.hole_count   = rsp_data_ff.hole_count;

   // A failed item never reports a block index.
   a_fail_no_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.ok |-> rsp_data_ff.block_index == '0)
      else $error("failed item reports a block index");

   // With no holes there can be no free words.
   a_no_holes_no_words: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.hole_count == '0 |-> rsp_data_ff.free_words == '0)
      else $error("free words without holes");

   // Header writes stay inside the store.
   a_write_in_store: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> mem_req.wr_addr < wfba_pkg::POS_W'(STORE_WORDS))
      else $error("header write outside the store");

   // A result is only handed over when the output register can take it.
   a_take_only_when_room: assert property (@(posedge clock) disable iff (reset)
      res_take |=> rsp_valid_ff && rsp_data_ff == $past(res))
      else $error("result lost at the output register");
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import wfba_pkg::*;

   localparam int WORDS      = STORE_WORDS_DEF;
   localparam int RANDOM_ITEMS = 1280;
   localparam int QUIET_AFTER  = 1100;
   localparam int HOLD_CYCLES  = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4 clock = ~clock;

   wfba_req_if req_ch ();
   wfba_rsp_if rsp_ch ();

   worst_fit_block_allocator_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Shadow copy of the header store. Bits 15..0 hold a block's last word and bit 16 marks
   // it free. Only headers reached through the chain are ever read.
   logic [HDR_W-1:0] shadow_hdr [WORDS];

   // Results still owed by the allocator, oldest first.
   result_type owed_results [$];
   // Block indices currently handed out, and a few that were given back.
   int live_blocks [$];
   int freed_blocks [$];

   int  n_errors = 0;
   int  n_sent = 0;
   int  n_seen = 0;
   bit  quiet = 1'b0;
   bit  stim_done = 1'b0;

   // One row of the directed stimulus. When has_exp is set the expected result is the one
   // typed in the row; otherwise the shadow model supplies it.
   typedef struct {
      kind_type   kind;
      int         arg;
      bit         has_exp;
      result_type exp;
   } stim_row_type;

   function automatic int next_start(int h);
      return int'(shadow_hdr[h][LAST_W-1:0]) + 1;
   endfunction

   function automatic bit hdr_free(int h);
      return shadow_hdr[h][HDR_FREE_BIT];
   endfunction

   function automatic void write_hdr(int h, int nxt, bit fr);
      shadow_hdr[h] = {fr, LAST_W'(nxt - 1)};
   endfunction

   // Walk the chain and total up the free holes that hold at least one word.
   function automatic void hole_stats(output int total, output int largest, output int count);
      int h;
      int sz;
      h = 0;
      total = 0;
      largest = 0;
      count = 0;
      while (h < WORDS) begin
         sz = next_start(h) - h - 1;
         if (hdr_free(h) && sz != 0) begin
            count++;
            total += sz;
            if (sz > largest) largest = sz;
         end
         h = next_start(h);
      end
   endfunction

   // Exact fit wins on first sight; otherwise the first largest hole is split.
   function automatic bit carve_block(int want, output int idx);
      int h;
      int n;
      int sz;
      int best;
      int best_h;
      int cut;
      h = 0;
      best = 0;
      best_h = 0;
      idx = 0;
      if (want == 0) return 1'b0;
      while (h < WORDS) begin
         n = next_start(h);
         sz = n - h - 1;
         if (hdr_free(h)) begin
            if (sz == want) begin
               write_hdr(h, n, 1'b0);
               idx = h + 1;
               return 1'b1;
            end
            if (sz > best) begin
               best = sz;
               best_h = h;
            end
         end
         h = n;
      end
      if (best > want) begin
         cut = best_h + want + 1;
         write_hdr(cut, next_start(best_h), 1'b1);
         write_hdr(best_h, cut, 1'b0);
         idx = best_h + 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Release a block and coalesce it with free neighbors on both sides.
   function automatic bit release_block(int idx);
      int target;
      int h;
      int prev;
      int start_h;
      int end_h;
      bit has_prev;
      h = 0;
      prev = 0;
      has_prev = 1'b0;
      if (idx == 0) return 1'b0;
      target = idx - 1;
      while (h < WORDS && h < target) begin
         prev = h;
         has_prev = 1'b1;
         h = next_start(h);
      end
      if (h >= WORDS || h != target || hdr_free(h)) return 1'b0;
      end_h = next_start(h);
      if (end_h < WORDS && hdr_free(end_h)) end_h = next_start(end_h);
      start_h = h;
      if (has_prev && hdr_free(prev)) start_h = prev;
      write_hdr(start_h, end_h, 1'b1);
      return 1'b1;
   endfunction

   // Apply one transfer to the shadow store and return the result it must produce.
   function automatic result_type apply_item(kind_type kind, int arg);
      result_type r;
      int idx;
      int total;
      int largest;
      int count;
      bit ok;
      idx = 0;
      if (kind == KIND_ALLOC) ok = carve_block(arg, idx);
      else ok = release_block(arg);
      if (!ok || kind != KIND_ALLOC) idx = 0;
      hole_stats(total, largest, count);
      r.ok = ok;
      r.block_index = FIELD_W'(idx);
      r.free_words = FIELD_W'(total);
      r.largest_hole = FIELD_W'(largest);
      r.hole_count = FIELD_W'(count);
      return r;
   endfunction

   function automatic result_type mk_res(bit ok, int bi, int fw, int lh, int hc);
      result_type r;
      r.ok = ok;
      r.block_index = FIELD_W'(bi);
      r.free_words = FIELD_W'(fw);
      r.largest_hole = FIELD_W'(lh);
      r.hole_count = FIELD_W'(hc);
      return r;
   endfunction

   // Keep the list of handed-out blocks in step with the shadow store.
   function automatic void track_blocks(kind_type kind, int arg, result_type r);
      if (!r.ok) return;
      if (kind == KIND_ALLOC) begin
         live_blocks.push_back(int'(r.block_index));
      end else begin
         foreach (live_blocks[i]) begin
            if (live_blocks[i] == arg) begin
               live_blocks.delete(i);
               break;
            end
         end
         freed_blocks.push_back(arg);
         if (freed_blocks.size() > 16) void'(freed_blocks.pop_front());
      end
   endfunction

   // Offer one item at the falling edge and hold it until the allocator takes it. The
   // expectation is formed at the accepting edge, so the shadow store follows the block.
   task automatic send_item(kind_type kind, int arg, bit has_exp, result_type exp);
      result_type r;
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.kind = kind;
      req_ch.amount_or_index = FIELD_W'(arg);
      do @(posedge clock); while (!req_ch.ready);
      r = apply_item(kind, arg);
      owed_results.push_back(has_exp ? exp : r);
      track_blocks(kind, arg, r);
      n_sent++;
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   // Pick a random item. Allocations are mostly small so the chain stays short, with
   // occasional zero, oversized, exact-largest and largest-minus-one requests. Frees are
   // mostly of live blocks, with some bad, repeated or misaligned indices mixed in.
   task automatic random_item(output kind_type kind, output int arg);
      int r;
      int total;
      int largest;
      int count;
      int free_pct;
      free_pct = (live_blocks.size() > 60) ? 70 : 45;
      r = $urandom_range(0, 99);
      if (live_blocks.size() == 0 || r >= free_pct) begin
         kind = KIND_ALLOC;
         hole_stats(total, largest, count);
         r = $urandom_range(0, 99);
         if (r < 78) arg = $urandom_range(1, 48);
         else if (r < 84) arg = $urandom_range(0, 32767);
         else if (r < 87) arg = 0;
         else if (r < 92) arg = largest;
         else if (r < 96) arg = (largest > 1) ? largest - 1 : 1;
         else arg = $urandom_range(49, 600);
      end else begin
         kind = KIND_FREE;
         r = $urandom_range(0, 99);
         if (r < 82) arg = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
         else if (r < 87) arg = live_blocks[$urandom_range(0, live_blocks.size() - 1)] + 1;
         else if (r < 93) arg = $urandom_range(0, 32767);
         else if (r < 97 && freed_blocks.size() > 0)
            arg = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
         else arg = 0;
      end
   endtask

   // Stimulus: a short directed table, then random traffic.
   initial begin
      stim_row_type rows [$];
      result_type none;
      kind_type k;
      int a;
      none = '0;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_ALLOC;
      req_ch.amount_or_index = '0;
      for (int h = 0; h < WORDS; h++) shadow_hdr[h] = '0;
      write_hdr(0, WORDS, 1'b1);

      // After reset the whole store is one free hole of 32767 words.
      rows.push_back('{KIND_ALLOC, 0,     1, mk_res(0, 0, 32767, 32767, 1)});
      rows.push_back('{KIND_ALLOC, 32767, 1, mk_res(1, 1, 0, 0, 0)});
      rows.push_back('{KIND_ALLOC, 1,     1, mk_res(0, 0, 0, 0, 0)});
      rows.push_back('{KIND_FREE,  1,     1, mk_res(1, 0, 32767, 32767, 1)});
      rows.push_back('{KIND_FREE,  1,     1, mk_res(0, 0, 32767, 32767, 1)});
      rows.push_back('{KIND_FREE,  0,     1, mk_res(0, 0, 32767, 32767, 1)});
      rows.push_back('{KIND_FREE,  32767, 1, mk_res(0, 0, 32767, 32767, 1)});
      // A split that leaves a free block with no usable words, which is not a hole.
      rows.push_back('{KIND_ALLOC, 32766, 1, mk_res(1, 1, 0, 0, 0)});
      rows.push_back('{KIND_FREE,  1,     1, mk_res(1, 0, 32767, 32767, 1)});
      rows.push_back('{KIND_ALLOC, 10,    1, mk_res(1, 1, 32756, 32756, 1)});
      rows.push_back('{KIND_ALLOC, 20,    1, mk_res(1, 12, 32735, 32735, 1)});
      rows.push_back('{KIND_FREE,  5,     1, mk_res(0, 0, 32735, 32735, 1)});
      rows.push_back('{KIND_FREE,  1,     1, mk_res(1, 0, 32745, 32735, 2)});
      rows.push_back('{KIND_ALLOC, 10,    1, mk_res(1, 1, 32735, 32735, 1)});
      rows.push_back('{KIND_FREE,  12,    1, mk_res(1, 0, 32756, 32756, 1)});
      rows.push_back('{KIND_FREE,  1,     1, mk_res(1, 0, 32767, 32767, 1)});
      // The rows below are checked against the shadow store only.
      rows.push_back('{KIND_ALLOC, 16384, 0, none});
      rows.push_back('{KIND_ALLOC, 100,   0, none});
      rows.push_back('{KIND_ALLOC, 200,   0, none});
      rows.push_back('{KIND_FREE,  16386, 0, none});
      rows.push_back('{KIND_ALLOC, 100,   0, none});
      rows.push_back('{KIND_FREE,  16386, 0, none});
      rows.push_back('{KIND_FREE,  16487, 0, none});
      rows.push_back('{KIND_FREE,  1,     0, none});
      rows.push_back('{KIND_ALLOC, 32767, 0, none});

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) send_item(rows[i].kind, rows[i].arg, rows[i].has_exp, rows[i].exp);

      // Hand back whatever the directed part left allocated, then go random.
      while (live_blocks.size() > 0) send_item(KIND_FREE, live_blocks[0], 1'b0, none);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (n_sent > QUIET_AFTER) quiet = 1'b1;
         random_item(k, a);
         send_item(k, a, 1'b0, none);
      end
      stim_done = 1'b1;
   end

   // Result side: random ready bursts, one long hold-off while the sender keeps offering
   // items so the allocator backs up onto its input, and a field-by-field check of each
   // transfer against the oldest owed result.
   initial begin
      result_type want;
      int stall;
      bit held;
      stall = 0;
      held = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && n_sent >= 300) begin
            held = 1'b1;
            stall = HOLD_CYCLES;
         end else if (stall == 0 && !quiet && $urandom_range(0, 3) == 0) begin
            stall = $urandom_range(1, 16);
         end
         rsp_ch.ready = (stall == 0) && !reset;
         if (stall > 0) stall--;
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            n_seen++;
            if (owed_results.size() == 0) begin
               $error("result transfer with nothing owed");
               n_errors++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_ch.ok !== want.ok) begin
                  $error("ok: expected %0d, got %0d", want.ok, rsp_ch.ok);
                  n_errors++;
               end
               if (rsp_ch.block_index !== want.block_index) begin
                  $error("block_index: expected %0d, got %0d",
                         want.block_index, rsp_ch.block_index);
                  n_errors++;
               end
               if (rsp_ch.free_words !== want.free_words) begin
                  $error("free_words: expected %0d, got %0d",
                         want.free_words, rsp_ch.free_words);
                  n_errors++;
               end
               if (rsp_ch.largest_hole !== want.largest_hole) begin
                  $error("largest_hole: expected %0d, got %0d",
                         want.largest_hole, rsp_ch.largest_hole);
                  n_errors++;
               end
               if (rsp_ch.hole_count !== want.hole_count) begin
                  $error("hole_count: expected %0d, got %0d",
                         want.hole_count, rsp_ch.hole_count);
                  n_errors++;
               end
            end
         end
      end
   end

   // Wind down once every item is in and every owed result has come back, leaving room
   // for a stray extra result to show up.
   initial begin
      wait (stim_done);
      while (owed_results.size() != 0) @(posedge clock);
      repeat (2000) @(posedge clock);
      if (n_errors == 0 && owed_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Hard stop in case the allocator hangs.
   initial begin
      #60_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/wfba_pkg.sv
rtl/core/wfba_intf.sv
rtl/core/wfba_hdr_mem.sv
rtl/core/wfba_ctrl.sv
rtl/core/worst_fit_block_allocator_top.sv
dv/tb.sv
